// File: hdl/clock_page_replacement_defines.svh
// Assertion macros for the checker file.
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/cpr_pkg.sv
`timescale 1ns / 1ps
package cpr_pkg;

	// Default sizing
	localparam int FRAMES_DEF     = 16;
	localparam int PAGE_WIDTH_DEF = 16;

	// Fixed field widths
	localparam int CFG_W         = 5;
	localparam int OUTCOME_W     = 2;
	localparam int FRAME_INDEX_W = 4;
	localparam int FAULT_W       = 16;

	localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = CFG_W'(16);
	localparam logic [FAULT_W-1:0] FAULT_MAX       = '1;

	// Result codes
	localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_FAULT = 2'd2;

	// Command broadcast to every cell
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_LOOKUP,
		OP_NORM,
		OP_FILL,
		OP_SWEEP,
		OP_REPLACE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     tok_active;  // hand currently sits inside the active range
	} cell_cmd_t;

	// Per-cell status seen by the controller
	typedef struct packed {
		logic hand;     // clock hand token
		logic ref_bit;  // second-chance bit
		logic first;    // first matching frame of this lookup
		logic active;   // frame lies below the active count
	} cell_stat_t;

endpackage

// File: hdl/cpr_cell.sv
`timescale 1ns / 1ps
module cpr_cell #(
	parameter int PAGE_WIDTH = cpr_pkg::PAGE_WIDTH_DEF,
	parameter int FRAMES     = cpr_pkg::FRAMES_DEF,
	parameter int CELL_IDX   = 0,
	localparam int NW        = $clog2(FRAMES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpr_pkg::cell_cmd_t    cmd,
	input  logic [PAGE_WIDTH-1:0] key,
	input  logic [NW-1:0]         n_act,
	input  logic [NW-1:0]         used,
	input  logic                  found_in,
	input  logic                  pass_in,
	output logic                  found_out,
	output logic                  pass_fwd,
	output logic                  pass_wrap,
	output cpr_pkg::cell_stat_t   stat,
	output logic [PAGE_WIDTH-1:0] page
);
	import cpr_pkg::*;

	localparam logic [NW-1:0] IDX_N = NW'(CELL_IDX);

	logic [PAGE_WIDTH-1:0] page_q;
	logic                  bit_q;
	logic                  tok_q;
	logic                  match;
	logic                  first;
	logic                  is_last;
	logic                  pass;
	logic                  tok_d;

	// Lookup: compare against the key, priority runs down the chain
	assign match     = (cmd.op == OP_LOOKUP) && (IDX_N < used) && (page_q == key);
	assign first     = match && !found_in;
	assign found_out = found_in || match;

	// Hand token moves to the neighbor, last active cell wraps to cell 0
	assign is_last   = (IDX_N == n_act - NW'(1));
	assign pass      = tok_q && ((cmd.op == OP_FILL) || (cmd.op == OP_REPLACE) ||
		((cmd.op == OP_SWEEP) && bit_q));
	assign pass_fwd  = pass && !is_last;
	assign pass_wrap = pass && is_last;

	always_comb begin
		if (cmd.op == OP_NORM) begin
			tok_d = cmd.tok_active ? tok_q : (CELL_IDX == 0);
		end else begin
			tok_d = (tok_q && !pass) || pass_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= (CELL_IDX == 0);
		end else begin
			tok_q <= tok_d;
		end
	end

	// Second-chance bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOOKUP: begin
					if (first) bit_q <= 1'b1;
				end
				OP_FILL: begin
					if (IDX_N == used) bit_q <= 1'b1;
				end
				OP_SWEEP: begin
					if (tok_q) bit_q <= 1'b0;
				end
				OP_REPLACE: begin
					if (tok_q) bit_q <= 1'b1;
				end
				default: begin
					bit_q <= bit_q;
				end
			endcase
		end
	end

	// Page storage, no reset
	always_ff @(posedge clk) begin
		if (((cmd.op == OP_FILL) && (IDX_N == used)) || ((cmd.op == OP_REPLACE) && tok_q)) begin
			page_q <= key;
		end
	end

	assign stat.hand    = tok_q;
	assign stat.ref_bit = bit_q;
	assign stat.first   = first;
	assign stat.active  = (IDX_N < n_act);
	assign page         = page_q;

endmodule

// File: hdl/clock_page_replacement.sv
`timescale 1ns / 1ps
// Clock (second-chance) page replacement.
// Input channel (in_valid/in_ready/page_number): one page reference per
// transaction. Output channel (out_valid/out_ready/...): one result per
// reference: outcome, frame now holding the page, evicted page and the
// saturating fault count. Config channel (cfg_valid/cfg_ready/cfg_data)
// writes the active frame count; write it only while the block is idle.
// Frames are a row of cells; the clock hand is a token passed one cell per
// cycle. A hit runs through the lookup and result steps, a fill of a free
// frame through lookup, normalize, fill and result, and a fault through
// lookup, normalize, 1..n+1 sweep steps (n active frames), replace and
// result. One reference is processed at a time; the next one is taken the
// cycle after the result is loaded.
// The result sits in an output register: a stalled receiver holds that
// result while the next reference is accepted and processed, and the block
// then waits in its last step until the register frees.
// Reset clears all second-chance bits, the fill count, the fault count and
// puts the hand at frame 0; frame count returns to 16.
module clock_page_replacement #(
	parameter int FRAMES     = cpr_pkg::FRAMES_DEF,
	parameter int PAGE_WIDTH = cpr_pkg::PAGE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cpr_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [PAGE_WIDTH-1:0]             page_number,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cpr_pkg::OUTCOME_W-1:0]     outcome,
	output logic [cpr_pkg::FRAME_INDEX_W-1:0] frame_index,
	output logic [PAGE_WIDTH-1:0]             evicted_page,
	output logic [cpr_pkg::FAULT_W-1:0]       fault_count
);
	import cpr_pkg::*;

	localparam int NW    = $clog2(FRAMES + 1);
	localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CMP_W = (NW > CFG_W) ? NW : CFG_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_NORM,
		ST_FILL,
		ST_SWEEP,
		ST_REPLACE,
		ST_RESULT
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         cfg_q;
	logic [PAGE_WIDTH-1:0]    key_q;
	logic [NW-1:0]            filled_q;
	logic [FAULT_W-1:0]       faults_q;
	logic [OUTCOME_W-1:0]     res_outcome_q;
	logic [FW-1:0]            res_slot_q;
	logic [PAGE_WIDTH-1:0]    res_evict_q;
	logic                     out_valid_q;
	logic [OUTCOME_W-1:0]     outcome_q;
	logic [FRAME_INDEX_W-1:0] frame_index_q;
	logic [PAGE_WIDTH-1:0]    evicted_q;
	logic [FAULT_W-1:0]       fault_count_q;

	logic [CMP_W-1:0]      n_wide;
	logic [NW-1:0]         n_act;
	logic [NW-1:0]         used;
	cell_cmd_t             cmd;
	cell_stat_t            stat [FRAMES];
	logic [PAGE_WIDTH-1:0] pages [FRAMES];
	logic [FRAMES-1:0]     found_out;
	logic [FRAMES-1:0]     pass_fwd;
	logic [FRAMES-1:0]     pass_wrap;
	logic [FRAMES-1:0]     pass_in;
	logic [FRAMES-1:0]     hand_vec;
	logic [FRAMES-1:0]     victim_vec;
	logic [FRAMES-1:0]     first_vec;
	logic                  tok_active;
	logic                  victim;
	logic [FW-1:0]         hit_idx;
	logic [FW-1:0]         hand_idx;
	logic [PAGE_WIDTH-1:0] hand_page;
	logic                  out_free;

	// Config register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= FRAME_COUNT_RST;
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	// Active frame count clamped to 1..FRAMES, filled frames within it
	always_comb begin
		n_wide = CMP_W'(cfg_q);
		if (n_wide == '0) begin
			n_wide = CMP_W'(1);
		end else if (n_wide > CMP_W'(FRAMES)) begin
			n_wide = CMP_W'(FRAMES);
		end
		n_act = NW'(n_wide);
		used  = (filled_q < n_act) ? filled_q : n_act;
	end

	// Command to the cells
	always_comb begin
		case (state_q)
			ST_LOOK:    cmd.op = OP_LOOKUP;
			ST_NORM:    cmd.op = OP_NORM;
			ST_FILL:    cmd.op = OP_FILL;
			ST_SWEEP:   cmd.op = OP_SWEEP;
			ST_REPLACE: cmd.op = OP_REPLACE;
			default:    cmd.op = OP_IDLE;
		endcase
		cmd.tok_active = tok_active;
	end

	// Row of frame cells
	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign pass_in[g] = |pass_wrap;
		end else begin : g_body
			assign pass_in[g] = pass_fwd[g-1];
		end

		cpr_cell #(
			.PAGE_WIDTH(PAGE_WIDTH),
			.FRAMES    (FRAMES),
			.CELL_IDX  (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.key      (key_q),
			.n_act    (n_act),
			.used     (used),
			.found_in ((g == 0) ? 1'b0 : found_out[(g == 0) ? 0 : g - 1]),
			.pass_in  (pass_in[g]),
			.found_out(found_out[g]),
			.pass_fwd (pass_fwd[g]),
			.pass_wrap(pass_wrap[g]),
			.stat     (stat[g]),
			.page     (pages[g])
		);
	end

	// Gather cell status: hand position, victim, hit index, page under hand
	always_comb begin
		tok_active = 1'b0;
		hit_idx    = '0;
		hand_idx   = '0;
		hand_page  = '0;
		for (int i = 0; i < FRAMES; i++) begin
			hand_vec[i]   = stat[i].hand;
			first_vec[i]  = stat[i].first;
			victim_vec[i] = stat[i].hand && !stat[i].ref_bit;
			tok_active    = tok_active || (stat[i].hand && stat[i].active);
			if (first_vec[i]) hit_idx = hit_idx | FW'(i);
			if (hand_vec[i]) begin
				hand_idx  = hand_idx | FW'(i);
				hand_page = hand_page | pages[i];
			end
		end
		victim = |victim_vec;
	end

	assign out_free = !out_valid_q || out_ready;

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			filled_q    <= '0;
			faults_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the result step reloads the register itself
			if (out_valid_q && out_ready && (state_q != ST_RESULT)) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q   <= page_number;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (found_out[FRAMES-1]) begin
						res_outcome_q <= OUT_HIT;
						res_slot_q    <= hit_idx;
						res_evict_q   <= '0;
						state_q       <= ST_RESULT;
					end else begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					state_q <= (used < n_act) ? ST_FILL : ST_SWEEP;
				end
				ST_FILL: begin
					filled_q      <= used + NW'(1);
					res_outcome_q <= OUT_FILL;
					res_slot_q    <= FW'(used);
					res_evict_q   <= '0;
					state_q       <= ST_RESULT;
				end
				ST_SWEEP: begin
					if (victim) begin
						res_slot_q  <= hand_idx;
						res_evict_q <= hand_page;
						state_q     <= ST_REPLACE;
					end
				end
				ST_REPLACE: begin
					if (faults_q != FAULT_MAX) faults_q <= faults_q + FAULT_W'(1);
					res_outcome_q <= OUT_FAULT;
					state_q       <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						outcome_q     <= res_outcome_q;
						frame_index_q <= FRAME_INDEX_W'(res_slot_q);
						evicted_q     <= res_evict_q;
						fault_count_q <= faults_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign outcome      = outcome_q;
	assign frame_index  = frame_index_q;
	assign evicted_page = evicted_q;
	assign fault_count  = fault_count_q;

endmodule

// File: hdl/cpr_checker.sv
`timescale 1ns / 1ps
`include "clock_page_replacement_defines.svh"
module cpr_checker #(
	parameter int PAGE_WIDTH = cpr_pkg::PAGE_WIDTH_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [PAGE_WIDTH-1:0]             page_number,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [cpr_pkg::OUTCOME_W-1:0]     outcome,
	input logic [cpr_pkg::FRAME_INDEX_W-1:0] frame_index,
	input logic [PAGE_WIDTH-1:0]             evicted_page,
	input logic [cpr_pkg::FAULT_W-1:0]       fault_count
);
	import cpr_pkg::*;

	// Stalled result transaction holds its outcome, frame index and fault count
	`CPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(outcome) && $stable(frame_index) && $stable(fault_count),
		"result changed while stalled")

	// Only the three defined outcome codes appear
	`CPR_ASSERT_NOW(a_outcome_code, out_valid,
		outcome == OUT_HIT || outcome == OUT_FILL || outcome == OUT_FAULT,
		"undefined outcome code")

	// Nothing is evicted unless a frame was replaced
	`CPR_ASSERT_NOW(a_no_evict, out_valid && outcome != OUT_FAULT,
		evicted_page == '0, "eviction reported without a fault")

	// One reference at a time: input closes right after a transaction
	`CPR_ASSERT_NEXT(a_one_busy, in_valid && in_ready, !in_ready,
		"input accepted while a reference is in progress")

	// A waiting input transaction keeps its page
	`CPR_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
		in_valid && $stable(page_number), "input changed while waiting")

endmodule

bind clock_page_replacement cpr_checker #(.PAGE_WIDTH(PAGE_WIDTH)) u_cpr_checker (.*);
